>>> design/sca_pkg.sv
// Shared types, widths and constants for the sensor calibrate and average block.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sca_pkg;

   localparam int DATA_W       = 16;
   localparam int TEMP_RAW_W   = 11;
   localparam int HUMID_RAW_W  = 10;
   localparam int CAL_RAW_W    = 12;
   localparam int PROD_W       = 28;
   localparam int FRAC_BITS    = 12;
   localparam int ELAPSED_W    = 16;

   localparam int WINDOW_DEPTH_DEF = 3;

   localparam int FAST_PERIOD   = 1000;
   localparam int SLOW_PERIOD   = 2000;
   localparam int PERIOD_FACTOR = 2;

   localparam logic [ELAPSED_W-1:0] FAST_LIMIT = ELAPSED_W'(PERIOD_FACTOR * FAST_PERIOD);
   localparam logic [ELAPSED_W-1:0] SLOW_LIMIT = ELAPSED_W'(PERIOD_FACTOR * SLOW_PERIOD);

   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_RESET = 1'b1;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [REG_IDX_W-1:0] REG_SLEEP_STEP   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_MODEL_FAST   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_TEMP_GAIN    = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_TEMP_OFFSET  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_HUMID_GAIN   = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_HUMID_OFFSET = 3'd5;

   localparam logic signed [DATA_W-1:0] GAIN_UNITY = 16'sd4096;

   typedef struct packed {
      logic [ELAPSED_W-1:0]     sleep_step;
      logic                     model_is_fast;
      logic signed [DATA_W-1:0] temp_gain;
      logic signed [DATA_W-1:0] temp_offset;
      logic signed [DATA_W-1:0] humid_gain;
      logic signed [DATA_W-1:0] humid_offset;
   } csr_cfg_type;

endpackage

`default_nettype wire

>>> design/sca_csr.sv
// Configuration register file behind an APB-style port.
// Depends on sca_pkg for the register map and the configuration struct.
`timescale 1ns / 1ps
`default_nettype none

module sca_csr
   import sca_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output csr_cfg_type                cfg
);

   csr_cfg_type           cfg_ff;
   csr_cfg_type           cfg_in;
   logic [REG_IDX_W-1:0]  index;
   logic                  write_en;

   assign index      = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            REG_SLEEP_STEP:   cfg_in.sleep_step    = csr_pwdata[ELAPSED_W-1:0];
            REG_MODEL_FAST:   cfg_in.model_is_fast = csr_pwdata[0];
            REG_TEMP_GAIN:    cfg_in.temp_gain     = csr_pwdata[DATA_W-1:0];
            REG_TEMP_OFFSET:  cfg_in.temp_offset   = csr_pwdata[DATA_W-1:0];
            REG_HUMID_GAIN:   cfg_in.humid_gain    = csr_pwdata[DATA_W-1:0];
            REG_HUMID_OFFSET: cfg_in.humid_offset  = csr_pwdata[DATA_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_SLEEP_STEP:   csr_prdata = CSR_DATA_W'(cfg_ff.sleep_step);
         REG_MODEL_FAST:   csr_prdata = CSR_DATA_W'(cfg_ff.model_is_fast);
         REG_TEMP_GAIN:    csr_prdata = CSR_DATA_W'(unsigned'(cfg_ff.temp_gain));
         REG_TEMP_OFFSET:  csr_prdata = CSR_DATA_W'(unsigned'(cfg_ff.temp_offset));
         REG_HUMID_GAIN:   csr_prdata = CSR_DATA_W'(unsigned'(cfg_ff.humid_gain));
         REG_HUMID_OFFSET: csr_prdata = CSR_DATA_W'(unsigned'(cfg_ff.humid_offset));
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sleep_step    <= '0;
         cfg_ff.model_is_fast <= 1'b1;
         cfg_ff.temp_gain     <= GAIN_UNITY;
         cfg_ff.temp_offset   <= '0;
         cfg_ff.humid_gain    <= GAIN_UNITY;
         cfg_ff.humid_offset  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

>>> design/sca_cal.sv
// Shared calibration unit: registered gain multiply, then shift, offset add and saturate.
// Depends on sca_pkg for the operand and product widths.
`timescale 1ns / 1ps
`default_nettype none

module sca_cal
   import sca_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic signed [DATA_W-1:0]    gain,
   input  wire logic signed [CAL_RAW_W-1:0] raw,
   input  wire logic signed [DATA_W-1:0]    offset,
   output logic signed      [DATA_W-1:0]    result
);

   logic signed [PROD_W-1:0] product_ff;
   logic signed [PROD_W-1:0] product_in;
   logic signed [DATA_W-1:0] offset_ff;
   logic signed [DATA_W-1:0] shifted;
   logic signed [DATA_W:0]   total;

   assign product_in = PROD_W'(gain) * PROD_W'(raw);
   assign shifted    = product_ff[PROD_W-1:FRAC_BITS];
   assign total      = {shifted[DATA_W-1], shifted} + {offset_ff[DATA_W-1], offset_ff};

   always_comb begin
      if (total[DATA_W] != total[DATA_W-1]) begin
         result = total[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
         result = total[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
      offset_ff  <= offset;
   end

endmodule

`default_nettype wire

>>> design/sca_div.sv
// Bit-serial restoring divider: signed window sum over fill count, truncated toward zero.
// Depends on sca_pkg for the result width.
`timescale 1ns / 1ps
`default_nettype none

module sca_div
   import sca_pkg::*;
#(
   parameter int SUM_W  = 19,
   parameter int FILL_W = 2
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic signed [SUM_W-1:0] dividend,
   input  wire logic [FILL_W-1:0]       divisor,
   output logic                         done,
   output logic signed [DATA_W-1:0]     quotient
);

   localparam int CNT_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [FILL_W-1:0] rem_ff, rem_in;
   logic [FILL_W-1:0] den_ff;
   logic              neg_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              done_ff, done_in;
   logic [SUM_W-1:0]  magnitude;
   logic [FILL_W:0]   rem_shift;
   logic              fits;
   logic [SUM_W-1:0]  signed_quo;

   assign magnitude  = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
   assign rem_shift  = {rem_ff, quo_ff[SUM_W-1]};
   assign fits       = rem_shift >= {1'b0, den_ff};
   assign signed_quo = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign quotient   = signed_quo[DATA_W-1:0];
   assign done       = done_ff;

   always_comb begin
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      if (start) begin
         quo_in   = magnitude;
         rem_in   = '0;
         count_in = CNT_W'(SUM_W);
      end else if (count_ff != '0) begin
         quo_in   = {quo_ff[SUM_W-2:0], fits};
         rem_in   = fits ? FILL_W'(rem_shift - {1'b0, den_ff}) : rem_shift[FILL_W-1:0];
         count_in = count_ff - 1'b1;
         done_in  = (count_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         den_ff <= divisor;
         neg_ff <= dividend[SUM_W-1];
      end
   end

endmodule

`default_nettype wire

>>> design/sensor_calibrate_average.sv
// Sensor calibrate and average: a non-sampling word goes to the done state after accept.
// A sampling word is calibrated, pushed into the window and averaged, SUM_W = 17+clog2(WINDOW_DEPTH),
// with the bit-serial divider run once per channel. The next word is taken the cycle after
// the result is loaded; a waiting result does not block the sequencer until its final step.
// Synchronous reset: registers to defaults, timer and window fill to zero, response valid cleared.
// Depends on sca_pkg, sca_csr, sca_cal and sca_div.
`timescale 1ns / 1ps
`default_nettype none

module sensor_calibrate_average
   import sca_pkg::*;
#(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_command,
   input  wire logic signed [TEMP_RAW_W-1:0]  req_temp_raw,
   input  wire logic [HUMID_RAW_W-1:0]        req_humid_raw,
   input  wire logic                          req_reading_valid,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_updated,
   output logic                               rsp_error,
   output logic signed [DATA_W-1:0]           rsp_temp_out,
   output logic signed [DATA_W-1:0]           rsp_humid_out,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]         csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]         csr_pwdata,
   output logic      [CSR_DATA_W-1:0]         csr_prdata,
   output logic                               csr_pready
);

   localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
   localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int SUM_W  = DATA_W + $clog2(WINDOW_DEPTH) + 1;

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_MUL_T     = 4'd1;
   localparam logic [3:0] ST_MUL_H     = 4'd2;
   localparam logic [3:0] ST_PUSH      = 4'd3;
   localparam logic [3:0] ST_DIV_T_GO  = 4'd4;
   localparam logic [3:0] ST_DIV_T_RUN = 4'd5;
   localparam logic [3:0] ST_DIV_H_GO  = 4'd6;
   localparam logic [3:0] ST_DIV_H_RUN = 4'd7;
   localparam logic [3:0] ST_DONE      = 4'd8;

   csr_cfg_type cfg;

   logic [3:0]                     state_ff, state_in;
   logic [ELAPSED_W-1:0]           elapsed_ff, elapsed_in;
   logic [FILL_W-1:0]              fill_ff, fill_in;
   logic [SLOT_W-1:0]              slot_ff, slot_in;
   logic signed [SUM_W-1:0]        sum_t_ff, sum_t_in;
   logic signed [SUM_W-1:0]        sum_h_ff, sum_h_in;
   logic signed [DATA_W-1:0]       temp_held_ff, temp_held_in;
   logic signed [DATA_W-1:0]       humid_held_ff, humid_held_in;
   logic                           upd_ff, upd_in;
   logic                           err_ff, err_in;
   logic signed [TEMP_RAW_W-1:0]   temp_raw_ff;
   logic [HUMID_RAW_W-1:0]         humid_raw_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_updated_ff;
   logic                           rsp_error_ff;
   logic signed [DATA_W-1:0]       rsp_temp_ff;
   logic signed [DATA_W-1:0]       rsp_humid_ff;

   logic signed [DATA_W-1:0]       temp_win [WINDOW_DEPTH];
   logic signed [DATA_W-1:0]       humid_win [WINDOW_DEPTH];

   logic                           accept;
   logic                           load_rsp;
   logic                           full;
   logic                           sample;
   logic [ELAPSED_W-1:0]           limit;
   logic [ELAPSED_W-1:0]           elapsed_base;
   logic [ELAPSED_W:0]             elapsed_sum;
   logic                           temp_we;
   logic                           humid_we;
   logic signed [DATA_W-1:0]       old_t;
   logic signed [DATA_W-1:0]       old_h;

   logic signed [DATA_W-1:0]       cal_gain;
   logic signed [CAL_RAW_W-1:0]    cal_raw;
   logic signed [DATA_W-1:0]       cal_offset;
   logic signed [DATA_W-1:0]       cal_y;
   logic signed [SUM_W-1:0]        cal_y_ext;

   logic                           div_start;
   logic signed [SUM_W-1:0]        div_dividend;
   logic                           div_done;
   logic signed [DATA_W-1:0]       div_quotient;

   sca_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sca_cal u_cal (
      .clock  (clock),
      .gain   (cal_gain),
      .raw    (cal_raw),
      .offset (cal_offset),
      .result (cal_y)
   );

   sca_div #(
      .SUM_W  (SUM_W),
      .FILL_W (FILL_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (fill_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign req_stall     = (state_ff != ST_IDLE);
   assign accept        = req_valid & ~req_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_updated   = rsp_updated_ff;
   assign rsp_error     = rsp_error_ff;
   assign rsp_temp_out  = rsp_temp_ff;
   assign rsp_humid_out = rsp_humid_ff;

   assign load_rsp     = (state_ff == ST_DONE) & (~rsp_valid_ff | ~rsp_stall);
   assign full         = (fill_ff == FILL_W'(WINDOW_DEPTH));
   assign limit        = cfg.model_is_fast ? FAST_LIMIT : SLOW_LIMIT;
   assign sample       = (elapsed_ff >= limit);
   assign elapsed_base = sample ? '0 : elapsed_ff;
   assign elapsed_sum  = {1'b0, elapsed_base} + {1'b0, cfg.sleep_step};
   assign old_t        = temp_win[slot_ff];
   assign old_h        = humid_win[slot_ff];
   assign cal_y_ext    = {{(SUM_W-DATA_W){cal_y[DATA_W-1]}}, cal_y};
   assign temp_we      = (state_ff == ST_MUL_H);
   assign humid_we     = (state_ff == ST_PUSH);

   always_comb begin
      if (state_ff == ST_MUL_T) begin
         cal_gain   = cfg.temp_gain;
         cal_raw    = {temp_raw_ff[TEMP_RAW_W-1], temp_raw_ff};
         cal_offset = cfg.temp_offset;
      end else begin
         cal_gain   = cfg.humid_gain;
         cal_raw    = {{(CAL_RAW_W-HUMID_RAW_W){1'b0}}, humid_raw_ff};
         cal_offset = cfg.humid_offset;
      end
   end

   assign div_start    = (state_ff == ST_DIV_T_GO) | (state_ff == ST_DIV_H_GO);
   assign div_dividend = (state_ff == ST_DIV_H_GO) ? sum_h_ff : sum_t_ff;

   always_comb begin
      state_in      = state_ff;
      elapsed_in    = elapsed_ff;
      fill_in       = fill_ff;
      slot_in       = slot_ff;
      sum_t_in      = sum_t_ff;
      sum_h_in      = sum_h_ff;
      temp_held_in  = temp_held_ff;
      humid_held_in = humid_held_ff;
      upd_in        = upd_ff;
      err_in        = err_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DONE;
               upd_in   = 1'b0;
               err_in   = 1'b0;
               if (req_command == CMD_RESET) begin
                  elapsed_in = '0;
                  fill_in    = '0;
                  slot_in    = '0;
                  sum_t_in   = '0;
                  sum_h_in   = '0;
                  if (req_reading_valid) begin
                     upd_in   = 1'b1;
                     state_in = ST_MUL_T;
                  end else begin
                     err_in        = 1'b1;
                     temp_held_in  = '0;
                     humid_held_in = '0;
                  end
               end else begin
                  elapsed_in = elapsed_sum[ELAPSED_W] ? '1 : elapsed_sum[ELAPSED_W-1:0];
                  if (sample && req_reading_valid) begin
                     upd_in   = 1'b1;
                     state_in = ST_MUL_T;
                  end else if (sample) begin
                     err_in = 1'b1;
                  end
               end
            end
         end
         ST_MUL_T: begin
            state_in = ST_MUL_H;
         end
         ST_MUL_H: begin
            sum_t_in = sum_t_ff + cal_y_ext
                     - (full ? {{(SUM_W-DATA_W){old_t[DATA_W-1]}}, old_t} : '0);
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            sum_h_in = sum_h_ff + cal_y_ext
                     - (full ? {{(SUM_W-DATA_W){old_h[DATA_W-1]}}, old_h} : '0);
            slot_in  = (slot_ff == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
            if (!full) begin
               fill_in = fill_ff + 1'b1;
            end
            state_in = ST_DIV_T_GO;
         end
         ST_DIV_T_GO: begin
            state_in = ST_DIV_T_RUN;
         end
         ST_DIV_T_RUN: begin
            if (div_done) begin
               temp_held_in = div_quotient;
               state_in     = ST_DIV_H_GO;
            end
         end
         ST_DIV_H_GO: begin
            state_in = ST_DIV_H_RUN;
         end
         ST_DIV_H_RUN: begin
            if (div_done) begin
               humid_held_in = div_quotient;
               state_in      = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         elapsed_ff    <= '0;
         fill_ff       <= '0;
         slot_ff       <= '0;
         sum_t_ff      <= '0;
         sum_h_ff      <= '0;
         temp_held_ff  <= '0;
         humid_held_ff <= '0;
         upd_ff        <= 1'b0;
         err_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         elapsed_ff    <= elapsed_in;
         fill_ff       <= fill_in;
         slot_ff       <= slot_in;
         sum_t_ff      <= sum_t_in;
         sum_h_ff      <= sum_h_in;
         temp_held_ff  <= temp_held_in;
         humid_held_ff <= humid_held_in;
         upd_ff        <= upd_in;
         err_ff        <= err_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         temp_raw_ff  <= req_temp_raw;
         humid_raw_ff <= req_humid_raw;
      end
      if (load_rsp) begin
         rsp_updated_ff <= upd_ff;
         rsp_error_ff   <= err_ff;
         rsp_temp_ff    <= temp_held_ff;
         rsp_humid_ff   <= humid_held_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (temp_we) begin
         temp_win[slot_ff] <= cal_y;
      end
      if (humid_we) begin
         humid_win[slot_ff] <= cal_y;
      end
   end

endmodule

`default_nettype wire
